[src/dss_pkg.sv]
// Shared types and constants for the diffusion stencil step block.
// Depends on nothing; every other file of the block imports it.
package dss_pkg;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_FLUSH  = 1'b1;

   localparam logic [1:0] CSR_COLS = 2'd0;
   localparam logic [1:0] CSR_ROWS = 2'd1;
   localparam logic [1:0] CSR_GAIN = 2'd2;

   localparam logic [8:0]  COLS_RESET = 9'd200;
   localparam logic [10:0] ROWS_RESET = 11'd200;
   localparam logic [15:0] GAIN_RESET = 16'd6554;

   localparam int MIN_DIM    = 5;
   localparam int GAIN_SHIFT = 18;
   localparam int QUEUE_DEPTH = 8;

   typedef struct packed {
      logic        command;
      logic [31:0] sample;
   } req_type;

   typedef struct packed {
      logic [31:0] new_value;
      logic [9:0]  cell_row;
      logic [7:0]  cell_col;
      logic        frame_end;
   } rsp_type;

   typedef struct packed {
      logic       valid;
      logic       interior;
      logic [9:0] cell_row;
      logic [7:0] cell_col;
      logic       frame_end;
   } work_type;

   typedef struct packed {
      logic signed [31:0] north;
      logic signed [31:0] south;
      logic signed [31:0] west;
      logic signed [31:0] east;
      logic signed [31:0] center;
   } taps_type;

endpackage

[src/dss_front.sv]
// Front part: position counters, fill tracking, the row store and its reads.
// Depends on dss_pkg.
module dss_front import dss_pkg::*; #(
   parameter int MAX_COLS = 256,
   parameter int MAX_ROWS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  req_type     req_data,
   input  logic [8:0]  cols_cfg,
   input  logic [10:0] rows_cfg,
   output work_type    work,
   output taps_type    taps
);

   localparam int CW  = $clog2(MAX_COLS);
   localparam int UW  = $clog2(MAX_COLS + 1);
   localparam int RW  = $clog2(MAX_ROWS);
   localparam int RUW = $clog2(MAX_ROWS + 1);
   localparam int PW  = UW + 1;
   localparam int DEPTH = 4 * MAX_COLS;
   localparam int AW  = $clog2(DEPTH);

   logic [CW-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [RW-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [1:0]    in_slot_ff, in_slot_in, out_slot_ff, out_slot_in;
   logic [PW-1:0] pend_ff, pend_in;
   logic [UW-1:0] cols;
   logic [RUW-1:0] rows;
   logic          flush, emit, writes, interior, last_cell;
   logic [AW-1:0] a_wr, a_n, a_s, a_w, a_e, a_c;
   logic [1:0]    north_slot;
   logic [CW-1:0] west_col, east_col;
   logic [CW:0]   east_wide;

   logic [31:0] mem_a [0:DEPTH-1];
   logic [31:0] mem_b [0:DEPTH-1];
   logic [31:0] mem_c [0:DEPTH-1];
   logic [31:0] rd_n_ff, rd_c_ff, rd_s_ff, rd_w_ff, rd_e_ff, smp_ff;
   logic        hit_c_ff, hit_s_ff, hit_w_ff, hit_e_ff;
   work_type    work_ff, work_in;

   function automatic logic [AW-1:0] slot_addr(input logic [1:0] slot,
                                               input logic [CW-1:0] col);
      slot_addr = AW'(slot) * AW'(MAX_COLS) + AW'(col);
   endfunction

   always_comb begin
      if (32'(cols_cfg) < 32'(MIN_DIM)) cols = UW'(MIN_DIM);
      else if (32'(cols_cfg) > 32'(MAX_COLS)) cols = UW'(MAX_COLS);
      else cols = UW'(cols_cfg);
      if (32'(rows_cfg) < 32'(MIN_DIM)) rows = RUW'(MIN_DIM);
      else if (32'(rows_cfg) > 32'(MAX_ROWS)) rows = RUW'(MAX_ROWS);
      else rows = RUW'(rows_cfg);
   end

   assign flush  = (req_data.command == CMD_FLUSH);
   assign writes = accept && !flush;
   assign emit   = accept && (flush ? (pend_ff != '0) : (pend_ff >= {cols, 1'b0}));

   always_comb begin
      pend_in = pend_ff;
      if (accept) begin
         if (flush && pend_ff != '0) pend_in = pend_ff - 1'b1;
         else if (!flush && !emit) pend_in = pend_ff + 1'b1;
      end
      in_col_in = in_col_ff; in_row_in = in_row_ff; in_slot_in = in_slot_ff;
      if (writes) begin
         if (32'(in_col_ff) + 1 >= 32'(cols)) begin
            in_col_in  = '0;
            in_slot_in = in_slot_ff + 2'd1;
            in_row_in  = (32'(in_row_ff) + 1 >= 32'(rows)) ? '0 : in_row_ff + 1'b1;
         end else begin
            in_col_in = in_col_ff + 1'b1;
         end
      end
      out_col_in = out_col_ff; out_row_in = out_row_ff; out_slot_in = out_slot_ff;
      if (emit) begin
         if (32'(out_col_ff) + 1 >= 32'(cols)) begin
            out_col_in  = '0;
            out_slot_in = out_slot_ff + 2'd1;
            out_row_in  = (32'(out_row_ff) + 1 >= 32'(rows)) ? '0 : out_row_ff + 1'b1;
         end else begin
            out_col_in = out_col_ff + 1'b1;
         end
      end
   end

   always_comb begin
      north_slot = (32'(out_row_ff) >= 2) ? out_slot_ff + 2'd2 : out_slot_ff + 2'd3;
      west_col   = (32'(out_col_ff) >= 2) ? out_col_ff - CW'(2) : '0;
      east_wide  = {1'b0, out_col_ff} + (CW+1)'(2);
      if (32'(east_wide) >= 32'(MAX_COLS)) east_wide = east_wide - (CW+1)'(MAX_COLS);
      east_col   = east_wide[CW-1:0];
      a_wr = slot_addr(in_slot_ff, in_col_ff);
      a_n  = slot_addr(north_slot, out_col_ff);
      a_c  = slot_addr(out_slot_ff, out_col_ff);
      a_s  = slot_addr(out_slot_ff + 2'd2, out_col_ff);
      a_w  = slot_addr(out_slot_ff, west_col);
      a_e  = slot_addr(out_slot_ff, east_col);
      interior  = (32'(out_row_ff) >= 1) && (32'(out_row_ff) + 3 <= 32'(rows))
               && (32'(out_col_ff) >= 1) && (32'(out_col_ff) + 3 <= 32'(cols));
      last_cell = (32'(out_row_ff) + 1 >= 32'(rows)) && (32'(out_col_ff) + 1 >= 32'(cols));
      work_in.valid     = emit;
      work_in.interior  = interior;
      work_in.cell_row  = 10'(out_row_ff);
      work_in.cell_col  = 8'(out_col_ff);
      work_in.frame_end = last_cell;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff <= '0; in_row_ff <= '0; in_slot_ff <= '0;
         out_col_ff <= '0; out_row_ff <= '0; out_slot_ff <= '0;
         pend_ff <= '0;
         work_ff <= '0;
      end else begin
         in_col_ff <= in_col_in; in_row_ff <= in_row_in; in_slot_ff <= in_slot_in;
         out_col_ff <= out_col_in; out_row_ff <= out_row_in; out_slot_ff <= out_slot_in;
         pend_ff <= pend_in;
         work_ff <= work_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rd_n_ff <= mem_a[a_n];
         rd_c_ff <= mem_a[a_c];
         rd_s_ff <= mem_b[a_s];
         rd_w_ff <= mem_b[a_w];
         rd_e_ff <= mem_c[a_e];
         smp_ff  <= req_data.sample;
         hit_c_ff <= writes && (a_wr == a_c);
         hit_s_ff <= writes && (a_wr == a_s);
         hit_w_ff <= writes && (a_wr == a_w);
         hit_e_ff <= writes && (a_wr == a_e);
      end
      if (writes) begin
         mem_a[a_wr] <= req_data.sample;
         mem_b[a_wr] <= req_data.sample;
         mem_c[a_wr] <= req_data.sample;
      end
   end

   assign work        = work_ff;
   assign taps.north  = rd_n_ff;
   assign taps.center = hit_c_ff ? smp_ff : rd_c_ff;
   assign taps.south  = hit_s_ff ? smp_ff : rd_s_ff;
   assign taps.west   = hit_w_ff ? smp_ff : rd_w_ff;
   assign taps.east   = hit_e_ff ? smp_ff : rd_e_ff;

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= {cols, 1'b0}) else $error("pending count above two rows");
   a_no_emit_empty: assert property (@(posedge clock) disable iff (reset)
      (accept && flush && pend_ff == '0) |=> !work_ff.valid)
      else $error("flush emitted an item with nothing pending");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      (accept && !flush && !emit) |=> pend_ff == $past(pend_ff) + 1'b1)
      else $error("fill count did not advance");

endmodule

[src/dss_calc.sv]
// Back part: Laplacian sum, gain multiply, floor, add and saturation.
// Depends on dss_pkg.
module dss_calc import dss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  work_type    work,
   input  taps_type    taps,
   input  logic [15:0] gain,
   output logic        push,
   output rsp_type     result,
   output logic [1:0]  busy
);

   work_type           w2_ff, w3_ff;
   logic signed [31:0] c2_ff, c3_ff;
   logic signed [34:0] lap2_ff, lap_in;
   logic signed [51:0] prod3_ff;
   logic signed [33:0] delta;
   logic signed [35:0] sum;
   logic signed [31:0] sat;

   always_comb begin
      lap_in = 35'(taps.north) + 35'(taps.south) + 35'(taps.west) + 35'(taps.east)
             - (35'(taps.center) <<< 2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w2_ff <= '0;
         w3_ff <= '0;
      end else begin
         w2_ff <= work;
         w3_ff <= w2_ff;
      end
   end

   always_ff @(posedge clock) begin
      c2_ff    <= taps.center;
      lap2_ff  <= lap_in;
      c3_ff    <= c2_ff;
      prod3_ff <= 52'($signed({1'b0, gain}) * lap2_ff);
   end

   always_comb begin
      delta = 34'(prod3_ff >>> GAIN_SHIFT);
      sum   = 36'(c3_ff) + 36'(delta);
      if (sum > 36'sh07FFFFFFF) sat = 32'sh7FFFFFFF;
      else if (sum < -36'sh080000000) sat = 32'sh80000000;
      else sat = 32'(sum);
   end

   assign push             = w3_ff.valid;
   assign result.new_value = w3_ff.interior ? sat : c3_ff;
   assign result.cell_row  = w3_ff.cell_row;
   assign result.cell_col  = w3_ff.cell_col;
   assign result.frame_end = w3_ff.frame_end;
   assign busy             = 2'(w2_ff.valid) + 2'(w3_ff.valid);

endmodule

[src/dss_queue.sv]
// Result queue that holds finished items until the consumer pops them.
// Depends on dss_pkg.
module dss_queue import dss_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   input  logic    pop,
   output logic    empty,
   output rsp_type head,
   output logic [$clog2(QUEUE_DEPTH):0] count
);

   localparam int IW = $clog2(QUEUE_DEPTH);

   rsp_type        slot_ff [0:QUEUE_DEPTH-1];
   logic [IW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [IW:0]    count_ff, count_in;
   logic           rd_en;

   assign rd_en = pop && (count_ff != '0);

   always_comb begin
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = rd_en ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + (IW+1)'(push) - (IW+1)'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; count_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_data;
   end

   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ff];
   assign count = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != (IW+1)'(QUEUE_DEPTH) || rd_en))
      else $error("item pushed into a full queue");
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rd_en && !push) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count did not drop on pop");
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("queue not empty after reset");

endmodule

[src/diffusion_stencil_step_top.sv]
// Top level of the diffusion stencil step block.
// Depends on dss_pkg, dss_front, dss_calc and dss_queue.
//
// Takes one grid sample or flush command per clock and returns each updated
// cell two rows after it entered, in raster order. An item is taken every
// cycle while full is low; each result goes through the registered store read,
// the sum stage, the multiply stage and the result queue. full rises when the
// eight-entry result queue plus the three items in flight could overflow. The
// user must write configuration only while idle; the block does not enforce it.
module diffusion_stencil_step_top import dss_pkg::*; #(
   parameter int MAX_COLS = 256,
   parameter int MAX_ROWS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  req_type     req_data,
   output logic        empty,
   input  logic        pop,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic [8:0]  cols_ff;
   logic [10:0] rows_ff;
   logic [15:0] gain_ff;
   logic        accept, calc_push;
   work_type    work;
   taps_type    taps;
   rsp_type     calc_result;
   logic [1:0]  busy;
   logic [$clog2(QUEUE_DEPTH):0] q_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= COLS_RESET;
         rows_ff <= ROWS_RESET;
         gain_ff <= GAIN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COLS: cols_ff <= csr_wdata[8:0];
            CSR_ROWS: rows_ff <= csr_wdata[10:0];
            CSR_GAIN: gain_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign full   = (32'(q_count) + 32'(busy) + 32'(work.valid)) >= QUEUE_DEPTH;
   assign accept = push && !full;

   dss_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
      .clock(clock), .reset(reset), .accept(accept), .req_data(req_data),
      .cols_cfg(cols_ff), .rows_cfg(rows_ff), .work(work), .taps(taps));

   dss_calc u_calc (
      .clock(clock), .reset(reset), .work(work), .taps(taps), .gain(gain_ff),
      .push(calc_push), .result(calc_result), .busy(busy));

   dss_queue u_queue (
      .clock(clock), .reset(reset), .push(calc_push), .push_data(calc_result),
      .pop(pop), .empty(empty), .head(rsp_data), .count(q_count));

endmodule
